// ----- hw/rtl/accumulator_stack_vm_core_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef ACCUMULATOR_STACK_VM_CORE_UNIT_ASSERT_SVH
`define ACCUMULATOR_STACK_VM_CORE_UNIT_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define ASVM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASVM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define ASVM_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/asvm_pkg.sv -----
package asvm_pkg;

   localparam int unsigned STRING_BYTES = 1024;
   localparam int unsigned TEXT_OFF_W   = 10;
   localparam int unsigned TEXT_CNT_W   = 11;

   typedef enum logic [4:0] {
      OP_MOV   = 5'd0,
      OP_LDR   = 5'd1,
      OP_STR   = 5'd2,
      OP_JMP   = 5'd3,
      OP_JZ    = 5'd4,
      OP_JNZ   = 5'd5,
      OP_PUSH  = 5'd6,
      OP_LEV   = 5'd7,
      OP_OR    = 5'd8,
      OP_XOR   = 5'd9,
      OP_AND   = 5'd10,
      OP_EQ    = 5'd11,
      OP_NE    = 5'd12,
      OP_LT    = 5'd13,
      OP_GT    = 5'd14,
      OP_LE    = 5'd15,
      OP_GE    = 5'd16,
      OP_ADD   = 5'd17,
      OP_SUB   = 5'd18,
      OP_MUL   = 5'd19,
      OP_DIV   = 5'd20,
      OP_MOD   = 5'd21,
      OP_WRITE = 5'd22,
      OP_PRINT = 5'd23,
      OP_EXIT  = 5'd24
   } opcode_type;

   localparam logic [2:0] REG_IMM = 3'd0;
   localparam logic [2:0] REG_ACC = 3'd1;
   localparam logic [2:0] REG_FP  = 3'd2;
   localparam logic [2:0] REG_SP  = 3'd3;
   localparam logic [2:0] REG_PC  = 3'd4;

   localparam logic [2:0] ST_CONTINUE = 3'd0;
   localparam logic [2:0] ST_PRINT    = 3'd1;
   localparam logic [2:0] ST_WRITE    = 3'd2;
   localparam logic [2:0] ST_EXIT     = 3'd3;
   localparam logic [2:0] ST_DIV_ZERO = 3'd4;
   localparam logic [2:0] ST_ILLEGAL  = 3'd5;

   localparam logic [1:0] CSR_ENTRY = 2'd0;
   localparam logic [1:0] CSR_SP    = 2'd1;
   localparam logic [1:0] CSR_FP    = 2'd2;

   typedef struct packed {
      logic [4:0]         func;
      logic [2:0]         dst_reg;
      logic [2:0]         base_reg;
      logic signed [31:0] immediate;
      logic [10:0]        text_length;
   } req_type;

   typedef struct packed {
      logic [15:0]        next_pc;
      logic [2:0]         status;
      logic signed [31:0] value;
      logic [9:0]         text_offset;
      logic [10:0]        text_count;
   } rsp_type;

   // Classified instruction handed from front to back.
   typedef struct packed {
      opcode_type  func;
      logic        illegal;
      logic [2:0]  dst_reg;
      logic [2:0]  base_reg;
      logic [31:0] immediate;
      logic [9:0]  text_offset;
      logic [10:0] text_count;
   } op_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] index;
      logic [15:0] data;
   } csr_req_type;

   typedef struct packed {
      logic        start;
      logic        want_rem;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LEV2,
      S_EXEC,
      S_DIV
   } back_state_type;

endpackage

// ----- hw/rtl/accumulator_stack_vm_core_unit.sv -----
// Channel | Direction | Handshake         | Payload
// req     | in        | req_valid/stall   | req_data  (func, regs, immediate, text length)
// rsp     | out       | rsp_valid/stall   | rsp_data  (next pc, status, value, text)
// csr     | in        | csr_valid/ready   | csr_index, csr_data (16-bit register value)
//
// Sequence: the back end makes one stack-port access per instruction, then executes;
// LEV makes two reads on the single stack port, and DIV/MOD runs the 32-step restoring
// divider. The front and the 2-entry queue take transfers meanwhile until it is full.
// Reset: synchronous; afterwards all STACK_BYTES/4 stack words (16384 by default) are
// swept to zero, with req_stall high. CSR writes are taken at any time.
// Stalls: rsp_stall holds the result register; the back end starts the next
// instruction in the cycle the held result transfers.
// STACK_BYTES must be a power of two.
module accumulator_stack_vm_core_unit #(
   parameter int unsigned STACK_BYTES = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  asvm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output asvm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data
);
   import asvm_pkg::*;

   logic        push;
   op_type      push_op;
   logic        pop;
   logic        queue_full;
   logic        head_valid;
   op_type      head;
   logic        clearing;
   csr_req_type csr_req;

   // registers only load live state, so every write is taken at once
   assign csr_ready     = 1'b1;
   assign csr_req.valid = csr_valid;
   assign csr_req.index = csr_index;
   assign csr_req.data  = csr_data;

   // front: classify each transfer, flag illegal encodings, clamp text counts
   asvm_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .queue_full(queue_full),
      .clearing  (clearing),
      .req_stall (req_stall),
      .push      (push),
      .push_op   (push_op)
   );

   // decouple front and back
   asvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .full      (queue_full),
      .head_valid(head_valid),
      .head      (head)
   );

   // back: architectural registers, stack store, divider, result register
   asvm_back #(
      .STACK_BYTES(STACK_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .csr_req   (csr_req),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

// ----- hw/rtl/asvm_front.sv -----
module asvm_front (
   input  logic              req_valid,
   input  asvm_pkg::req_type req_data,
   input  logic              queue_full,
   input  logic              clearing,
   output logic              req_stall,
   output logic              push,
   output asvm_pkg::op_type  push_op
);
   import asvm_pkg::*;

   logic        bad_d;
   logic        bad_b;
   logic [10:0] room;

   assign req_stall = queue_full | clearing;
   assign push      = req_valid & ~req_stall;

   assign bad_d = (req_data.dst_reg == REG_IMM) || (req_data.dst_reg > REG_PC);
   assign bad_b = req_data.base_reg > REG_PC;
   assign room  = 11'(STRING_BYTES) - {1'b0, req_data.immediate[9:0]};

   always_comb begin
      push_op.func        = opcode_type'(req_data.func);
      push_op.dst_reg     = req_data.dst_reg;
      push_op.base_reg    = req_data.base_reg;
      push_op.immediate   = req_data.immediate;
      push_op.text_offset = req_data.immediate[9:0];
      push_op.text_count  = (req_data.text_length > room) ? room : req_data.text_length;
      if (req_data.func inside {OP_MOV, OP_LDR, OP_STR}) begin
         push_op.illegal = bad_d | bad_b;
      end else if (req_data.func == OP_PUSH) begin
         push_op.illegal = bad_b;
      end else begin
         push_op.illegal = req_data.func > OP_EXIT;
      end
   end

endmodule

// ----- hw/rtl/asvm_queue.sv -----
module asvm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  asvm_pkg::op_type push_op,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output asvm_pkg::op_type head
);
   import asvm_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- hw/rtl/asvm_div.sv -----
module asvm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  asvm_pkg::div_req_type div_req,
   output logic                 done,
   output logic [31:0]          result
);
   import asvm_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] ub_ff, ub_in;
   logic        na_ff, na_in;
   logic        nb_ff, nb_in;
   logic        want_rem_ff, want_rem_in;
   logic [32:0] trial;

   assign done  = busy_ff && (count_ff == 6'd32);
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, ub_ff};

   always_comb begin
      busy_in     = busy_ff;
      count_in    = count_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      ub_in       = ub_ff;
      na_in       = na_ff;
      nb_in       = nb_ff;
      want_rem_in = want_rem_ff;
      if (div_req.start) begin
         busy_in     = 1'b1;
         count_in    = 6'd0;
         na_in       = div_req.dividend[31];
         nb_in       = div_req.divisor[31];
         quo_in      = div_req.dividend[31] ? (32'd0 - div_req.dividend) : div_req.dividend;
         ub_in       = div_req.divisor[31] ? (32'd0 - div_req.divisor) : div_req.divisor;
         rem_in      = 32'd0;
         want_rem_in = div_req.want_rem;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         count_in = count_ff + 6'd1;
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (want_rem_ff) begin
         result = na_ff ? (32'd0 - rem_ff) : rem_ff;
      end else begin
         result = (na_ff != nb_ff) ? (32'd0 - quo_ff) : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      ub_ff       <= ub_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      want_rem_ff <= want_rem_in;
   end

endmodule

// ----- hw/rtl/asvm_back.sv -----
module asvm_back #(
   parameter int unsigned STACK_BYTES = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  asvm_pkg::op_type      head,
   output logic                  pop,
   output logic                  clearing,
   input  asvm_pkg::csr_req_type csr_req,
   output logic                  rsp_valid,
   output asvm_pkg::rsp_type     rsp_data,
   input  logic                  rsp_stall
);
   import asvm_pkg::*;

   localparam int unsigned AW = $clog2(STACK_BYTES);
   localparam int unsigned IW = AW - 2;
   localparam int unsigned WORDS = STACK_BYTES / 4;

   back_state_type state_ff, state_in;

   logic [31:0] acc_ff, acc_in;
   logic [15:0] sp_ff, sp_in;
   logic [15:0] fp_ff, fp_in;
   logic [15:0] pc_ff, pc_in;
   op_type      op_ff, op_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [31:0] link_ff, link_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] stack_mem [WORDS];
   logic [31:0] rd_q_ff;
   logic          mem_we;
   logic [IW-1:0] mem_idx;
   logic [31:0]   mem_wd;

   logic [31:0] head_base, head_sum, head_addr;
   logic [31:0] lev_addr;
   logic        is_binop, is_div;
   logic [31:0] src_val, npc, bin_res;
   logic [31:0] mul_res;
   logic        emit, div_zero;
   div_req_type div_req;
   logic        div_done;
   logic [31:0] div_res;

   function automatic logic [31:0] reg_rd(logic [2:0] code, logic [15:0] pc_seen,
                                          logic [31:0] acc, logic [15:0] fp,
                                          logic [15:0] sp);
      logic [31:0] r;
      case (code)
         REG_ACC: r = acc;
         REG_FP:  r = {16'd0, fp};
         REG_SP:  r = {16'd0, sp};
         REG_PC:  r = {16'd0, pc_seen};
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   asvm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .done   (div_done),
      .result (div_res)
   );

   assign clearing  = state_ff == S_CLEAR;
   assign pop       = (state_ff == S_IDLE) && head_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign is_binop  = op_ff.func inside {[OP_OR:OP_MOD]};
   assign is_div    = (op_ff.func == OP_DIV) || (op_ff.func == OP_MOD);
   assign div_zero  = is_div && (acc_ff == 32'd0);
   assign mul_res   = rd_q_ff * acc_ff;

   // address of the first stack access, from the queue head
   always_comb begin
      head_base = (head.base_reg == REG_IMM) ? 32'd0 :
                  reg_rd(head.base_reg, pc_ff + 16'd3, acc_ff, fp_ff, sp_ff);
      head_sum  = head_base + head.immediate;
      case (head.func)
         OP_LDR, OP_STR: head_addr = head_sum;
         OP_PUSH:        head_addr = {16'd0, sp_ff};
         OP_LEV:         head_addr = {16'd0, fp_ff - 16'd8};
         default:        head_addr = {16'd0, sp_ff - 16'd4};
      endcase
      lev_addr = {16'd0, fp_ff - 16'd4};
   end

   always_comb begin
      case (op_ff.func)
         OP_OR:   bin_res = rd_q_ff | acc_ff;
         OP_XOR:  bin_res = rd_q_ff ^ acc_ff;
         OP_AND:  bin_res = rd_q_ff & acc_ff;
         OP_EQ:   bin_res = 32'(rd_q_ff == acc_ff);
         OP_NE:   bin_res = 32'(rd_q_ff != acc_ff);
         OP_LT:   bin_res = 32'($signed(rd_q_ff) < $signed(acc_ff));
         OP_GT:   bin_res = 32'($signed(rd_q_ff) > $signed(acc_ff));
         OP_LE:   bin_res = 32'($signed(rd_q_ff) <= $signed(acc_ff));
         OP_GE:   bin_res = 32'($signed(rd_q_ff) >= $signed(acc_ff));
         OP_ADD:  bin_res = rd_q_ff + acc_ff;
         OP_SUB:  bin_res = rd_q_ff - acc_ff;
         default: bin_res = mul_res;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (&clr_idx_ff) state_in = S_IDLE;
         S_IDLE: begin
            if (pop) state_in = (head.func == OP_LEV && !head.illegal) ? S_LEV2 : S_EXEC;
         end
         S_LEV2:  state_in = S_EXEC;
         S_EXEC: begin
            state_in = (!op_ff.illegal && is_binop && is_div && !div_zero) ? S_DIV : S_IDLE;
         end
         S_DIV:   if (div_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in       = acc_ff;
      sp_in        = sp_ff;
      fp_in        = fp_ff;
      pc_in        = pc_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      link_in      = link_ff;
      clr_idx_in   = clr_idx_ff;
      mem_we       = 1'b0;
      mem_idx      = addr_ff;
      mem_wd       = 32'd0;
      div_req      = '0;
      emit         = 1'b0;
      src_val      = 32'd0;
      npc          = {16'd0, pc_ff};
      rsp_data_in  = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_idx    = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IW'(1);
         end
         S_IDLE: begin
            mem_idx = head_addr[AW-1:2];
            if (pop) begin
               op_in   = head;
               addr_in = head_addr[AW-1:2];
            end
         end
         S_LEV2: begin
            mem_idx = lev_addr[AW-1:2];
            link_in = rd_q_ff;
         end
         S_EXEC: begin
            emit = 1'b1;
            if (op_ff.illegal) begin
               rsp_data_in.status = ST_ILLEGAL;
            end else begin
               case (op_ff.func)
                  OP_MOV: begin
                     src_val = (op_ff.base_reg == REG_IMM) ? op_ff.immediate :
                               reg_rd(op_ff.base_reg, pc_ff + 16'd3, acc_ff, fp_ff, sp_ff);
                     npc = {16'd0, pc_ff + ((op_ff.base_reg == REG_IMM) ? 16'd7 : 16'd3)};
                  end
                  OP_LDR: begin
                     src_val = rd_q_ff;
                     npc     = {16'd0, pc_ff + 16'd7};
                  end
                  OP_STR: begin
                     mem_we = 1'b1;
                     mem_wd = reg_rd(op_ff.dst_reg, pc_ff + 16'd7, acc_ff, fp_ff, sp_ff);
                     npc    = {16'd0, pc_ff + 16'd7};
                  end
                  OP_JMP: npc = op_ff.immediate;
                  OP_JZ:  npc = (acc_ff == 32'd0) ? op_ff.immediate : {16'd0, pc_ff + 16'd5};
                  OP_JNZ: npc = (acc_ff != 32'd0) ? op_ff.immediate : {16'd0, pc_ff + 16'd5};
                  OP_PUSH: begin
                     mem_we = 1'b1;
                     mem_wd = (op_ff.base_reg == REG_IMM) ? op_ff.immediate :
                              reg_rd(op_ff.base_reg, pc_ff + 16'd2, acc_ff, fp_ff, sp_ff);
                     sp_in  = sp_ff + 16'd4;
                     npc    = {16'd0, pc_ff + ((op_ff.base_reg == REG_IMM) ? 16'd6 : 16'd2)};
                  end
                  OP_LEV: begin
                     npc   = link_ff;
                     sp_in = fp_ff - 16'd8;
                     fp_in = rd_q_ff[15:0];
                  end
                  OP_WRITE: begin
                     npc                     = {16'd0, pc_ff + 16'd9};
                     rsp_data_in.status      = ST_WRITE;
                     rsp_data_in.text_offset = op_ff.text_offset;
                     rsp_data_in.text_count  = op_ff.text_count;
                  end
                  OP_PRINT, OP_EXIT: begin
                     npc                = {16'd0, pc_ff + 16'd1};
                     rsp_data_in.status = (op_ff.func == OP_PRINT) ? ST_PRINT : ST_EXIT;
                     rsp_data_in.value  = acc_ff;
                  end
                  default: begin
                     if (div_zero) begin
                        rsp_data_in.status = ST_DIV_ZERO;
                     end else if (is_div) begin
                        // hand the pair to the divider and hold the result
                        emit             = 1'b0;
                        div_req.start    = 1'b1;
                        div_req.want_rem = op_ff.func == OP_MOD;
                        div_req.dividend = rd_q_ff;
                        div_req.divisor  = acc_ff;
                     end else begin
                        acc_in = bin_res;
                        sp_in  = sp_ff - 16'd4;
                        npc    = {16'd0, pc_ff + 16'd1};
                     end
                  end
               endcase
               if (op_ff.func == OP_MOV || op_ff.func == OP_LDR) begin
                  case (op_ff.dst_reg)
                     REG_ACC: acc_in = src_val;
                     REG_FP:  fp_in  = src_val[15:0];
                     REG_SP:  sp_in  = src_val[15:0];
                     REG_PC:  npc    = src_val;
                     default: acc_in = acc_ff;
                  endcase
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               emit   = 1'b1;
               acc_in = div_res;
               sp_in  = sp_ff - 16'd4;
               npc    = {16'd0, pc_ff + 16'd1};
            end
         end
         default: mem_we = 1'b0;
      endcase

      if (emit) begin
         pc_in                = npc[15:0];
         rsp_valid_in         = 1'b1;
         rsp_data_in.next_pc  = npc[15:0];
      end

      if (csr_req.valid) begin
         case (csr_req.index)
            CSR_ENTRY: pc_in = csr_req.data;
            CSR_SP:    sp_in = csr_req.data;
            CSR_FP:    fp_in = csr_req.data;
            default:   pc_in = pc_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         acc_ff       <= 32'd0;
         sp_ff        <= 16'd0;
         fp_ff        <= 16'd0;
         pc_ff        <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         acc_ff       <= acc_in;
         sp_ff        <= sp_in;
         fp_ff        <= fp_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      addr_ff <= addr_in;
      link_ff <= link_in;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_idx] <= mem_wd;
      end
      rd_q_ff <= stack_mem[mem_idx];
   end

endmodule

// ----- hw/rtl/asvm_checker.sv -----
`include "accumulator_stack_vm_core_unit_assert.svh"

module asvm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input asvm_pkg::rsp_type rsp_data
);
   import asvm_pkg::*;

   `ASVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "held result changed")

   `ASVM_ASSERT_NOW(a_fault_quiet, clock, reset, rsp_valid && (rsp_data.status == ST_DIV_ZERO || rsp_data.status == ST_ILLEGAL), rsp_data.value == 32'sd0 && rsp_data.text_count == 11'd0, "fault result carries data")

   `ASVM_ASSERT_NOW(a_text_only_write, clock, reset, rsp_valid && rsp_data.status != ST_WRITE, rsp_data.text_count == 11'd0 && rsp_data.text_offset == 10'd0, "text fields outside write")

   `ASVM_ASSERT_NOW(a_text_clamp, clock, reset, rsp_valid && rsp_data.status == ST_WRITE, ({1'b0, rsp_data.text_count} + 12'(rsp_data.text_offset)) <= 12'd1024, "text count past string area")

   `ASVM_ASSERT_ALWAYS_NEXT(a_clear_stall, clock, reset, req_stall, "input taken during clear pass")

endmodule

bind accumulator_stack_vm_core_unit asvm_checker u_asvm_checker (.*);
